[hdl/pas_pkg.sv]
package pas_pkg;

    localparam int STATUS_W   = 9;
    localparam int CB_W       = 3;
    localparam int TIME_W     = 32;
    localparam int FAILS_W    = 8;
    localparam int PRIO_W     = 6;
    localparam int RANK_W     = 16;
    localparam int ACTION_W   = 3;
    localparam int POS_W      = 6;
    localparam int ACTIVE_W   = 7;

    localparam int PEERS_DEF  = 64;

    localparam logic [ACTIVE_W-1:0] ACTIVE_MAX = {ACTIVE_W{1'b1}};

    localparam int ST_CANCELLED  = 0;
    localparam int ST_NOFILE     = 1;
    localparam int ST_NOPARTS    = 2;
    localparam int ST_DEAD       = 3;
    localparam int ST_CONNECTING = 4;
    localparam int ST_ACCEPTED   = 5;
    localparam int ST_QUEUED     = 6;
    localparam int ST_CRYPTREQ   = 7;
    localparam int ST_LOWID      = 8;

    localparam logic [CB_W-1:0] CB_OTHER      = 3'd0;
    localparam logic [CB_W-1:0] CB_REQUESTED  = 3'd1;
    localparam logic [CB_W-1:0] CB_IMPOSSIBLE = 3'd2;
    localparam logic [CB_W-1:0] CB_FAILED     = 3'd3;
    localparam logic [CB_W-1:0] CB_TIMED_OUT  = 3'd4;

    localparam logic [ACTION_W-1:0] ACT_NONE     = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_CONNECT  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_RETRY    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_REASK    = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_CALLBACK = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_EXPIRE   = 3'd5;

    localparam int SLOT_CONNECT = 0;
    localparam int SLOT_RETRY   = 1;
    localparam int SLOT_REASK   = 2;
    localparam int SLOT_ONLY    = 3;
    localparam int SLOTS        = 4;

    typedef struct packed {
        logic [STATUS_W-1:0] status_flags;
        logic [CB_W-1:0]     callback_state;
        logic [TIME_W-1:0]   retry_time;
        logic [TIME_W-1:0]   now_time;
        logic [FAILS_W-1:0]  fail_count;
        logic [PRIO_W-1:0]   source_flags;
        logic [RANK_W-1:0]   queue_rank;
        logic                last_peer;
    } t_item;

    typedef struct packed {
        logic [SLOTS-1:0] offer;
        logic             cb_hit;
        logic             expire_hit;
        logic             active_hit;
    } t_class;

    typedef struct packed {
        logic             valid;
        logic [POS_W-1:0] index;
    } t_pick;

endpackage

[hdl/pas_in_if.sv]
interface pas_in_if;
    logic                           valid;
    logic                           ready;
    logic [pas_pkg::STATUS_W-1:0]   status_flags;
    logic [pas_pkg::CB_W-1:0]       callback_state;
    logic [pas_pkg::TIME_W-1:0]     retry_time;
    logic [pas_pkg::TIME_W-1:0]     now_time;
    logic [pas_pkg::FAILS_W-1:0]    fail_count;
    logic [pas_pkg::PRIO_W-1:0]     source_flags;
    logic [pas_pkg::RANK_W-1:0]     queue_rank;
    logic                           last_peer;

    modport source (
        output valid, status_flags, callback_state, retry_time, now_time,
               fail_count, source_flags, queue_rank, last_peer,
        input  ready
    );

    modport sink (
        input  valid, status_flags, callback_state, retry_time, now_time,
               fail_count, source_flags, queue_rank, last_peer,
        output ready
    );
endinterface

[hdl/pas_out_if.sv]
interface pas_out_if;
    logic                           valid;
    logic                           ready;
    logic [pas_pkg::ACTION_W-1:0]   action;
    logic [pas_pkg::POS_W-1:0]      action_peer;
    logic                           connect_found;
    logic [pas_pkg::POS_W-1:0]      connect_peer;
    logic [pas_pkg::ACTIVE_W-1:0]   active_count;

    modport source (
        output valid, action, action_peer, connect_found, connect_peer, active_count,
        input  ready
    );

    modport sink (
        input  valid, action, action_peer, connect_found, connect_peer, active_count,
        output ready
    );
endinterface

[hdl/pas_classify.sv]
module pas_classify (
    input  pas_pkg::t_item  i_item,
    output pas_pkg::t_class o_class
);

    logic cancelled;
    logic nofile;
    logic noparts;
    logic dead;
    logic connecting;
    logic accepted;
    logic queued;
    logic cryptreq;
    logic lowid;
    logic retry_due;
    logic cb_requested;
    logic cb_blocked;
    logic connectable;
    logic open_peer;
    logic live_peer;
    logic retry_hit;

    always_comb begin
        cancelled    = i_item.status_flags[pas_pkg::ST_CANCELLED];
        nofile       = i_item.status_flags[pas_pkg::ST_NOFILE];
        noparts      = i_item.status_flags[pas_pkg::ST_NOPARTS];
        dead         = i_item.status_flags[pas_pkg::ST_DEAD];
        connecting   = i_item.status_flags[pas_pkg::ST_CONNECTING];
        accepted     = i_item.status_flags[pas_pkg::ST_ACCEPTED];
        queued       = i_item.status_flags[pas_pkg::ST_QUEUED];
        cryptreq     = i_item.status_flags[pas_pkg::ST_CRYPTREQ];
        lowid        = i_item.status_flags[pas_pkg::ST_LOWID];
        retry_due    = i_item.retry_time <= i_item.now_time;
        cb_requested = i_item.callback_state == pas_pkg::CB_REQUESTED;
        cb_blocked   = (i_item.callback_state == pas_pkg::CB_IMPOSSIBLE) ||
                       (i_item.callback_state == pas_pkg::CB_FAILED) ||
                       (i_item.callback_state == pas_pkg::CB_TIMED_OUT);

        connectable = !cryptreq && !lowid && !cb_blocked && !connecting && !accepted &&
                      !queued && !nofile && !cancelled && !noparts && (!dead || retry_due);

        open_peer = !cancelled && !nofile;
        live_peer = open_peer && !cb_requested && !noparts;
        retry_hit = live_peer && dead && retry_due;

        o_class.cb_hit     = open_peer && cb_requested;
        o_class.expire_hit = retry_hit;
        o_class.active_hit = live_peer && !dead && (connecting || accepted);

        o_class.offer = '0;
        o_class.offer[pas_pkg::SLOT_RETRY]   = retry_hit && connectable;
        o_class.offer[pas_pkg::SLOT_REASK]   = live_peer && !dead && !connecting &&
                                               !accepted && queued;
        o_class.offer[pas_pkg::SLOT_CONNECT] = live_peer && !dead && !connecting &&
                                               !accepted && !queued && connectable;
        o_class.offer[pas_pkg::SLOT_ONLY]    = connectable;
    end

endmodule

[hdl/pas_slot.sv]
module pas_slot (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic                          i_clear,
    input  logic                          i_offer,
    input  logic [pas_pkg::POS_W-1:0]     i_pos,
    input  logic [pas_pkg::FAILS_W-1:0]   i_fails,
    input  logic [pas_pkg::PRIO_W-1:0]    i_prio,
    input  logic [pas_pkg::RANK_W-1:0]    i_rank,
    output pas_pkg::t_pick                o_pick_nxt
);

    logic                        r_valid;
    logic [pas_pkg::POS_W-1:0]   r_index;
    logic [pas_pkg::FAILS_W-1:0] r_fails;
    logic [pas_pkg::PRIO_W-1:0]  r_prio;
    logic [pas_pkg::RANK_W-1:0]  r_rank;
    logic                        better;
    logic                        take;

    always_comb begin
        if (i_fails != r_fails) begin
            better = i_fails < r_fails;
        end else if (i_prio != r_prio) begin
            better = i_prio > r_prio;
        end else begin
            better = (i_rank != '0) && ((r_rank == '0) || (i_rank < r_rank));
        end
        take             = i_offer && (!r_valid || better);
        o_pick_nxt.valid = r_valid || take;
        o_pick_nxt.index = take ? i_pos : r_index;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_step) begin
            r_valid <= i_clear ? 1'b0 : o_pick_nxt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && take) begin
            r_index <= i_pos;
            r_fails <= i_fails;
            r_prio  <= i_prio;
            r_rank  <= i_rank;
        end
    end

endmodule

[hdl/peer_action_selector_unit.sv]
// Peer action selector.
// Input channel i_pkt carries one peer record per word; the word with
// last_peer set closes the scan. Output channel o_res carries one result
// word per scan: the chosen action and its peer, the best connect-only
// peer and the count of active peers. Both channels use valid/ready.
// The cap on active peers is written through i_cfg_we/i_cfg_wdata; the
// user must write it only while the block is idle, which the block does
// not enforce; zero means no limit. A record waits in the input register
// and is folded into the scan state as it fires; a closing record's
// result goes to the output register that drives o_res. Throughput: one
// record per cycle unless a closing record waits, set by the single
// classify and compare-and-keep pass from input register to scan state.
// Reset clears the scan state, the cap and both valid flags.
// A stalled result holds in the output register while non-closing records
// keep flowing; a closing record waits in the input register until the
// output register is free.
module peer_action_selector_unit #(
    parameter int PEERS = pas_pkg::PEERS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pas_pkg::ACTIVE_W-1:0]    i_cfg_wdata,
    pas_in_if.sink                          i_pkt,
    pas_out_if.source                       o_res
);

    localparam int CNT_W = ($clog2(PEERS) > pas_pkg::POS_W) ? $clog2(PEERS) : pas_pkg::POS_W;
    localparam logic [CNT_W-1:0] POS_LAST = CNT_W'(PEERS - 1);

    logic [pas_pkg::ACTIVE_W-1:0]   r_cap;
    logic                           r_item_vld;
    pas_pkg::t_item                 r_item;
    logic [CNT_W-1:0]               r_scan_pos;
    logic                           r_cb_vld;
    logic [pas_pkg::POS_W-1:0]      r_cb_idx;
    logic                           r_exp_vld;
    logic [pas_pkg::POS_W-1:0]      r_exp_idx;
    logic [pas_pkg::ACTIVE_W-1:0]   r_active;
    logic                           r_out_vld;
    logic [pas_pkg::ACTION_W-1:0]   r_action;
    logic [pas_pkg::POS_W-1:0]      r_action_peer;
    logic                           r_connect_found;
    logic [pas_pkg::POS_W-1:0]      r_connect_peer;
    logic [pas_pkg::ACTIVE_W-1:0]   r_active_count;

    logic                           n_cb_vld;
    logic [pas_pkg::POS_W-1:0]      n_cb_idx;
    logic                           n_exp_vld;
    logic [pas_pkg::POS_W-1:0]      n_exp_idx;
    logic [pas_pkg::ACTIVE_W-1:0]   n_active;
    logic [CNT_W-1:0]               n_scan_pos;
    logic [pas_pkg::ACTION_W-1:0]   n_action;
    logic [pas_pkg::POS_W-1:0]      n_action_peer;

    logic                           accept;
    logic                           fire;
    logic                           close;
    logic                           can_start;
    logic [pas_pkg::POS_W-1:0]      pos;
    pas_pkg::t_class                cls;
    pas_pkg::t_pick                 pick [pas_pkg::SLOTS];

    assign pos    = r_scan_pos[pas_pkg::POS_W-1:0];
    assign fire   = r_item_vld && (!r_item.last_peer || !r_out_vld || o_res.ready);
    assign close  = fire && r_item.last_peer;
    assign accept = i_pkt.valid && i_pkt.ready;

    assign i_pkt.ready = !r_item_vld || fire;

    pas_classify u_classify (
        .i_item  (r_item),
        .o_class (cls)
    );

    for (genvar g = 0; g < pas_pkg::SLOTS; g++) begin : g_slot
        pas_slot u_slot (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_step     (fire),
            .i_clear    (close),
            .i_offer    (cls.offer[g]),
            .i_pos      (pos),
            .i_fails    (r_item.fail_count),
            .i_prio     (r_item.source_flags),
            .i_rank     (r_item.queue_rank),
            .o_pick_nxt (pick[g])
        );
    end

    always_comb begin
        n_cb_vld  = r_cb_vld || cls.cb_hit;
        n_cb_idx  = (!r_cb_vld && cls.cb_hit) ? pos : r_cb_idx;
        n_exp_vld = r_exp_vld || cls.expire_hit;
        n_exp_idx = (!r_exp_vld && cls.expire_hit) ? pos : r_exp_idx;
        n_active  = (cls.active_hit && (r_active != pas_pkg::ACTIVE_MAX)) ?
                    r_active + 1'b1 : r_active;
        n_scan_pos = (r_scan_pos == POS_LAST) ? '0 : r_scan_pos + 1'b1;

        can_start = (r_cap == '0) || (n_active < r_cap);

        n_action      = pas_pkg::ACT_NONE;
        n_action_peer = '0;
        if (can_start && pick[pas_pkg::SLOT_CONNECT].valid) begin
            n_action      = pas_pkg::ACT_CONNECT;
            n_action_peer = pick[pas_pkg::SLOT_CONNECT].index;
        end else if (can_start && pick[pas_pkg::SLOT_RETRY].valid) begin
            n_action      = pas_pkg::ACT_RETRY;
            n_action_peer = pick[pas_pkg::SLOT_RETRY].index;
        end else if (pick[pas_pkg::SLOT_REASK].valid) begin
            n_action      = pas_pkg::ACT_REASK;
            n_action_peer = pick[pas_pkg::SLOT_REASK].index;
        end else if (n_cb_vld) begin
            n_action      = pas_pkg::ACT_CALLBACK;
            n_action_peer = n_cb_idx;
        end else if (n_exp_vld) begin
            n_action      = pas_pkg::ACT_EXPIRE;
            n_action_peer = n_exp_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap      <= '0;
            r_item_vld <= 1'b0;
            r_scan_pos <= '0;
            r_cb_vld   <= 1'b0;
            r_exp_vld  <= 1'b0;
            r_active   <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (accept) begin
                r_item_vld <= 1'b1;
            end else if (fire) begin
                r_item_vld <= 1'b0;
            end
            if (close) begin
                r_scan_pos <= '0;
                r_cb_vld   <= 1'b0;
                r_exp_vld  <= 1'b0;
                r_active   <= '0;
            end else if (fire) begin
                r_scan_pos <= n_scan_pos;
                r_cb_vld   <= n_cb_vld;
                r_exp_vld  <= n_exp_vld;
                r_active   <= n_active;
            end
            if (close) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.status_flags   <= i_pkt.status_flags;
            r_item.callback_state <= i_pkt.callback_state;
            r_item.retry_time     <= i_pkt.retry_time;
            r_item.now_time       <= i_pkt.now_time;
            r_item.fail_count     <= i_pkt.fail_count;
            r_item.source_flags   <= i_pkt.source_flags;
            r_item.queue_rank     <= i_pkt.queue_rank;
            r_item.last_peer      <= i_pkt.last_peer;
        end
        if (fire) begin
            r_cb_idx  <= n_cb_idx;
            r_exp_idx <= n_exp_idx;
        end
        if (close) begin
            r_action        <= n_action;
            r_action_peer   <= n_action_peer;
            r_connect_found <= can_start && pick[pas_pkg::SLOT_ONLY].valid;
            r_connect_peer  <= pick[pas_pkg::SLOT_ONLY].valid ?
                               pick[pas_pkg::SLOT_ONLY].index : '0;
            r_active_count  <= n_active;
        end
    end

    assign o_res.valid         = r_out_vld;
    assign o_res.action        = r_action;
    assign o_res.action_peer   = r_action_peer;
    assign o_res.connect_found = r_connect_found;
    assign o_res.connect_peer  = r_connect_peer;
    assign o_res.active_count  = r_active_count;

    a_close_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_item_vld && r_item.last_peer && r_out_vld && !o_res.ready) |-> !fire)
        else $error("closing word folded while result register is held");

    a_scan_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        close |=> (r_scan_pos == '0) && !r_cb_vld && !r_exp_vld && (r_active == '0))
        else $error("scan state not cleared after closing word");

    a_pos_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !r_item.last_peer && (r_scan_pos == POS_LAST)) |=> (r_scan_pos == '0))
        else $error("scan position did not wrap");

    a_none_peer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.action == pas_pkg::ACT_NONE)) |-> (o_res.action_peer == '0))
        else $error("no action but nonzero action peer");

    a_found_needs_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        close |=> (!r_connect_found || ($past(pick[pas_pkg::SLOT_ONLY].valid) &&
                   ((r_cap == '0) || (r_active_count < r_cap)))))
        else $error("connect found without pick or with cap reached");

endmodule
